FILE: hdl/swtq_pkg.sv
`timescale 1ns / 1ps

package swtq_pkg;

    // Opcode carried in s_tuser.
    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Result status carried in m_tuser.
    localparam logic STATUS_WOKEN    = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    localparam int TICK_W     = 64;
    localparam int ID_W       = 8;
    localparam int DUR_W      = 32;

    // A single tick releases at most this many entries.
    localparam int MAX_RESULTS = 16;
    localparam int REL_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Command queue between front and back; depth must be a power of two.
    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);
    localparam int CMD_CNT_W       = $clog2(CMD_QUEUE_DEPTH + 1);

    typedef struct packed {
        logic             is_tick;
        logic [ID_W-1:0]  thread_id;
        logic [DUR_W-1:0] sleep_ticks;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0] woken_thread;
        logic            status;
        logic            last;
    } result_t;

endpackage

FILE: hdl/swtq_front.sv
`timescale 1ns / 1ps

module swtq_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_opcode,
    input  logic [7:0]          in_thread_id,
    input  logic [31:0]         in_sleep_ticks,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output swtq_pkg::cmd_t      cmd
);
    import swtq_pkg::*;

    logic stage_valid_reg, stage_valid_next;
    cmd_t cmd_reg, cmd_next;

    assign in_ready  = !stage_valid_reg || cmd_ready;
    assign cmd_valid = stage_valid_reg;
    assign cmd       = cmd_reg;

    // A sleep of zero ticks has no effect at all, so it is dropped here.
    always_comb begin
        stage_valid_next = stage_valid_reg;
        cmd_next         = cmd_reg;
        if (stage_valid_reg && cmd_ready) begin
            stage_valid_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            stage_valid_next     = (in_opcode == OP_TICK) || (in_sleep_ticks != '0);
            cmd_next.is_tick     = (in_opcode == OP_TICK);
            cmd_next.thread_id   = in_thread_id;
            cmd_next.sleep_ticks = in_sleep_ticks;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

FILE: hdl/swtq_cmd_fifo.sv
`timescale 1ns / 1ps

module swtq_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  swtq_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output swtq_pkg::cmd_t pop_cmd
);
    import swtq_pkg::*;

    cmd_t                 slot_reg [CMD_QUEUE_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != CMD_CNT_W'(CMD_QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers wrap naturally since the depth is a power of two.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/swtq_back.sv
`timescale 1ns / 1ps

module swtq_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  swtq_pkg::cmd_t    cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output swtq_pkg::result_t res
);
    import swtq_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RELEASE
    } state_t;

    state_t                state_reg, state_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [REL_CNT_W-1:0]  rel_cnt_reg, rel_cnt_next;
    logic [TICK_W-1:0]     wake_reg [QUEUE_DEPTH];
    logic [TICK_W-1:0]     wake_next [QUEUE_DEPTH];
    logic [ID_W-1:0]       id_reg [QUEUE_DEPTH];
    logic [ID_W-1:0]       id_next [QUEUE_DEPTH];
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;

    logic                  out_free;
    logic                  queue_full;
    logic                  due0, due1;
    logic [TICK_W-1:0]     wake_new;
    logic [QUEUE_DEPTH-1:0] later;
    logic [QUEUE_DEPTH-1:0] take_new;
    logic                  do_insert, do_shift;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign out_free  = !out_valid_reg || res_ready;

    assign queue_full = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign wake_new   = tick_reg + {{(TICK_W-DUR_W){1'b0}}, cmd.sleep_ticks};

    // Head due now, and whether the entry behind it is due as well, which
    // decides the last flag of the release at the head.
    assign due0 = (occ_reg != '0) && (rel_cnt_reg < REL_CNT_W'(MAX_RESULTS))
                  && (wake_reg[0] <= tick_reg);
    assign due1 = (occ_reg > OCC_W'(1)) && (rel_cnt_reg < REL_CNT_W'(MAX_RESULTS - 1))
                  && (wake_reg[1] <= tick_reg);

    // Every cell compares its own wake time with the new one; the list is
    // sorted, so the cells that wake strictly later form a tail.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            later[i] = (OCC_W'(i) >= occ_reg) || (wake_reg[i] > wake_new);
        end
        take_new[0] = later[0];
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            take_new[i] = later[i] && !later[i-1];
        end
    end

    always_comb begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        occ_next       = occ_reg;
        rel_cnt_next   = rel_cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cmd_ready      = 1'b0;
        do_insert      = 1'b0;
        do_shift       = 1'b0;

        if (out_valid_reg && res_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.is_tick) begin
                        cmd_ready    = 1'b1;
                        tick_next    = tick_reg + 1'b1;
                        rel_cnt_next = '0;
                        state_next   = ST_RELEASE;
                    end else if (queue_full) begin
                        if (out_free) begin
                            cmd_ready      = 1'b1;
                            out_valid_next = 1'b1;
                            out_next       = '{woken_thread: cmd.thread_id,
                                               status: STATUS_REJECTED, last: 1'b1};
                        end
                    end else begin
                        cmd_ready = 1'b1;
                        do_insert = 1'b1;
                        occ_next  = occ_reg + 1'b1;
                    end
                end
            end
            ST_RELEASE: begin
                if (!due0) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '{woken_thread: id_reg[0],
                                       status: STATUS_WOKEN, last: !due1};
                    do_shift       = 1'b1;
                    occ_next       = occ_reg - 1'b1;
                    rel_cnt_next   = rel_cnt_reg + 1'b1;
                    if (!due1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            wake_next[i] = wake_reg[i];
            id_next[i]   = id_reg[i];
        end
        if (do_insert) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (take_new[i]) begin
                    wake_next[i] = wake_new;
                    id_next[i]   = cmd.thread_id;
                end
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (later[i] && later[i-1]) begin
                    wake_next[i] = wake_reg[i-1];
                    id_next[i]   = id_reg[i-1];
                end
            end
        end else if (do_shift) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                wake_next[i] = wake_reg[i+1];
                id_next[i]   = id_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tick_reg      <= '0;
            occ_reg       <= '0;
            rel_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            occ_reg       <= occ_next;
            rel_cnt_reg   <= rel_cnt_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            wake_reg[i] <= wake_next[i];
            id_reg[i]   <= id_next[i];
        end
    end

endmodule

FILE: hdl/sorted_wakeup_timer_queue_unit.sv
`timescale 1ns / 1ps

// Sorted wake-up queue for sleeping threads, with its own 64-bit tick counter.
// The slave channel takes one request per transfer: a sleep request (tuser 0)
// inserts (now + sleep_ticks, thread_id) into a list sorted by wake time, ties
// in arrival order; a tick (tuser 1) advances the counter and then releases,
// head first, every entry that is due, up to 16 per tick, the final one with
// tlast set. A sleep of zero ticks is dropped, and a sleep into a full queue
// gives one transfer with tuser 1 (rejected) and tlast set.
// The front stage classifies requests and hands them through a four-entry
// command queue to the back end, so the slave side keeps taking requests
// while the back end releases entries or waits on the master side.
// On a sleep, every list cell compares its wake time with the new one in
// parallel and the tail shifts in the same cycle. A tick advances the
// counter, then the due entries leave, the list shifting one place per
// release. A tick's result passes the front stage, the command queue and
// the idle and release states; a rejection leaves from the idle state.
// Reset empties the list and clears the counter at once; there is no clearing
// pass. When the master side stalls, the output register holds its transfer,
// releases and rejections wait, the command queue filling before tready falls.
module sorted_wakeup_timer_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] thread_id, [39:8] sleep_ticks
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] woken_thread
    output logic        m_tuser,   // [0] status
    output logic        m_tlast
);
    import swtq_pkg::*;

    logic    front_valid, front_ready;
    cmd_t    front_cmd;
    logic    back_valid, back_ready;
    cmd_t    back_cmd;
    result_t res;

    swtq_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_opcode      (s_tuser),
        .in_thread_id   (s_tdata[7:0]),
        .in_sleep_ticks (s_tdata[39:8]),
        .cmd_valid      (front_valid),
        .cmd_ready      (front_ready),
        .cmd            (front_cmd)
    );

    swtq_cmd_fifo u_cmd_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    swtq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = res.woken_thread;
    assign m_tuser = res.status;
    assign m_tlast = res.last;

endmodule

FILE: hdl/swtq_checker.sv
`timescale 1ns / 1ps

module swtq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // A rejected sleep is always the only result of its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("rejected result without tlast");

    // Reset leaves the output register empty.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending right after reset");

endmodule

bind sorted_wakeup_timer_queue_unit swtq_checker u_swtq_checker (.*);
